FILE: rtl/hlbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlbc_pkg
// Shared types and constants of the block cache tag engine.
// ----------------------------------------------------------------------------
package hlbc_pkg;

    localparam int NUM_BUCKETS = 13;
    localparam int NUM_WAYS    = 5;
    localparam int SLOT_COUNT  = NUM_BUCKETS * NUM_WAYS;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] device_id;
        logic [31:0] block_number;
        logic [31:0] now_tick;
        logic [3:0]  slot_bucket;
        logic [2:0]  slot_way;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] bucket_index;
        logic [2:0] way_index;
        logic       needs_fill;
        logic [7:0] ref_count;
    } t_out;

    // One stored way
    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [31:0] tick;
        logic        vld;
    } t_entry;

endpackage
`default_nettype wire

FILE: rtl/hlbc_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlbc_mod
// Block number modulo the bucket count: residue fold, then reciprocal multiply.
// ----------------------------------------------------------------------------
module hlbc_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [3:0]       o_rem
);
    import hlbc_pkg::*;

    // residues of the 12-bit chunk weights
    localparam logic [5:0]  K12   = 6'((2**12) % NUM_BUCKETS);
    localparam logic [5:0]  K24   = 6'((2**24) % NUM_BUCKETS);
    // rounded-up reciprocal, exact for a folded value below 2^20
    localparam int          SH    = 26;
    localparam logic [26:0] RECIP = 27'(((2**SH) + NUM_BUCKETS - 1) / NUM_BUCKETS);

    logic [19:0] r_x;
    logic [19:0] r_q;
    logic [3:0]  r_rem;
    logic [1:0]  r_stg;
    logic [19:0] w_fold;
    logic [46:0] w_prod;

    // fold the three chunks into one small value with the same residue
    assign w_fold = 20'(i_value[31:24]) * 20'(K24)
                  + 20'(i_value[23:12]) * 20'(K12)
                  + 20'(i_value[11:0]);
    assign w_prod = 47'(r_x) * 47'(RECIP);

    // fold on start, quotient next cycle, remainder the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_stg  <= {r_stg[0], i_start};
            if (i_start) r_x <= w_fold;
            if (r_stg[0]) r_q <= w_prod[SH +: 20];
            if (r_stg[1]) begin
                r_rem  <= 4'(r_x - r_q * 20'(NUM_BUCKETS));
                o_done <= 1'b1;
            end
        end
    end

    assign o_rem = r_rem;

endmodule
`default_nettype wire

FILE: rtl/hashed_lru_block_cache_tags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_lru_block_cache_tags
// Tag and replacement engine of a hashed set-associative block cache.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel i_in_valid/o_in_stall carries a request beat (get, release,
//  pin, unpin). Output channel o_out_valid/i_out_stall returns one result
//  beat per request. One request is handled at a time; o_in_stall is high
//  from acceptance until its result has been taken, and during reset.
//  A get computes the bucket modulo (fold, reciprocal multiply, subtract),
//  then scans the ways one at a time through shared compare logic, a read
//  request state and a check state per way, first for a hit and then for
//  the oldest free way. Slot operations read, wait on and update their slot;
//  a bad slot goes straight to the result.
//  The next request is accepted the cycle after the result beat is taken.
//  The tag memory has one read and one write port; its read is registered,
//  which sets the per-way scan step.
//  After reset all ways are invalid with zero counts and stamps; the valid
//  bits clear at once, so no clearing pass is needed.
//  A stalled result beat holds until taken.
// ----------------------------------------------------------------------------
module hashed_lru_block_cache_tags (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire hlbc_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output hlbc_pkg::t_out       o_out_data
);
    import hlbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_HREQ, S_HCHK, S_FREQ, S_FCHK, S_ALLOC,
        S_SRD, S_SWAIT, S_SUPD, S_OUT
    } t_state;

    localparam int WW = $clog2(NUM_WAYS + 1);

    t_state          r_state;
    t_in             r_req;
    t_out            r_res;
    logic [3:0]      r_bucket;
    logic [WW-1:0]   r_way;
    logic [WW-1:0]   r_pick;
    logic            r_found;
    logic [31:0]     r_least;
    logic            r_out_valid;

    // tag memory, unset entries masked by valid flags
    t_entry          mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_set;
    logic [SLOT_W-1:0] r_raddr;
    t_entry          r_rdata;
    logic            r_rset;
    t_entry          w_rd;
    logic            w_we;
    logic [SLOT_W-1:0] w_waddr;
    t_entry          w_wdata;

    logic            w_mstart;
    logic            w_mdone;
    logic [3:0]      w_rem;
    logic [SLOT_W-1:0] w_base;
    logic [SLOT_W-1:0] w_slot;
    logic            w_hit;
    logic            w_free_better;

    hlbc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_value (i_in_data.block_number),
        .o_done  (w_mdone),
        .o_rem   (w_rem)
    );

    wire w_acc = i_in_valid && !o_in_stall;
    assign w_mstart = w_acc && i_in_data.opcode == OP_GET;
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_res;

    assign w_rd = r_rset ? r_rdata : '0;
    assign w_base = SLOT_W'(r_bucket * NUM_WAYS);
    assign w_slot = w_base + SLOT_W'(r_way);
    assign w_hit = w_rd.vld && w_rd.dev == r_req.device_id
                && w_rd.blk == r_req.block_number;
    // shared compare unit for the oldest free stamp
    assign w_free_better = w_rd.cnt == 8'd0 && (!r_found || w_rd.tick < r_least);

    // memory ports
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_raddr];
        if (w_we) mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rset <= 1'b0;
        else          r_rset <= r_set[r_raddr];
    end

    // write port driven from the sequencer
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot;
        w_wdata = w_rd;
        unique case (r_state)
            S_HCHK: begin
                if (w_hit) begin
                    w_we = 1'b1;
                    w_wdata.tick = r_req.now_tick;
                    if (w_rd.cnt != 8'hFF) w_wdata.cnt = w_rd.cnt + 8'd1;
                end
            end
            S_ALLOC: begin
                w_we    = r_found;
                w_waddr = w_base + SLOT_W'(r_pick);
                w_wdata.dev  = r_req.device_id;
                w_wdata.blk  = r_req.block_number;
                w_wdata.cnt  = 8'd1;
                w_wdata.tick = r_req.now_tick;
                w_wdata.vld  = 1'b1;
            end
            S_SUPD: begin
                if (r_req.opcode == OP_PIN) begin
                    if (w_rd.cnt != 8'hFF) begin
                        w_we = 1'b1;
                        w_wdata.cnt = w_rd.cnt + 8'd1;
                    end
                end else if (w_rd.cnt != 8'd0) begin
                    w_we = 1'b1;
                    w_wdata.cnt = w_rd.cnt - 8'd1;
                end
            end
            default: ;
        endcase
    end

    // sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_set       <= '0;
        end else begin
            if (w_we) r_set[w_waddr] <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_req <= i_in_data;
                        if (i_in_data.opcode == OP_GET) begin
                            r_state <= S_MOD;
                        end else if (i_in_data.slot_bucket >= 4'(NUM_BUCKETS)
                                  || i_in_data.slot_way >= 3'(NUM_WAYS)) begin
                            r_res <= '{ST_ERR, i_in_data.slot_bucket,
                                       i_in_data.slot_way, 1'b0, 8'd0};
                            r_out_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_bucket <= i_in_data.slot_bucket;
                            r_way    <= WW'(i_in_data.slot_way);
                            r_state  <= S_SRD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mdone) begin
                        r_bucket <= w_rem;
                        r_way    <= '0;
                        r_raddr  <= SLOT_W'(w_rem * NUM_WAYS);
                        r_state  <= S_HREQ;
                    end
                end
                S_HREQ: begin
                    r_state <= S_HCHK;
                end
                S_HCHK: begin
                    if (w_hit) begin
                        r_res <= '{(w_rd.cnt == 8'hFF) ? ST_ERR : ST_DONE,
                                   r_bucket, 3'(r_way), 1'b0,
                                   (w_rd.cnt == 8'hFF) ? w_rd.cnt : w_rd.cnt + 8'd1};
                        r_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_way == WW'(NUM_WAYS - 1)) begin
                        r_way   <= '0;
                        r_found <= 1'b0;
                        r_raddr <= w_base;
                        r_state <= S_FREQ;
                    end else begin
                        r_way   <= r_way + WW'(1);
                        r_raddr <= w_slot + SLOT_W'(1);
                        r_state <= S_HREQ;
                    end
                end
                S_FREQ: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (w_free_better) begin
                        r_found <= 1'b1;
                        r_least <= w_rd.tick;
                        r_pick  <= r_way;
                    end
                    if (r_way == WW'(NUM_WAYS - 1)) begin
                        r_state <= S_ALLOC;
                    end else begin
                        r_way   <= r_way + WW'(1);
                        r_raddr <= w_slot + SLOT_W'(1);
                        r_state <= S_FREQ;
                    end
                end
                S_ALLOC: begin
                    if (r_found) r_res <= '{ST_MISS, r_bucket, 3'(r_pick), 1'b1, 8'd1};
                    else         r_res <= '{ST_FULL, r_bucket, 3'd0, 1'b0, 8'd0};
                    r_out_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_SRD: begin
                    r_raddr <= w_slot;
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    r_state <= S_SUPD;
                end
                S_SUPD: begin
                    r_res.bucket_index <= r_bucket;
                    r_res.way_index    <= 3'(r_way);
                    r_res.needs_fill   <= 1'b0;
                    if (r_req.opcode == OP_PIN) begin
                        r_res.status    <= (w_rd.cnt == 8'hFF) ? ST_ERR : ST_DONE;
                        r_res.ref_count <= (w_rd.cnt == 8'hFF) ? w_rd.cnt
                                                               : w_rd.cnt + 8'd1;
                    end else begin
                        r_res.status    <= (w_rd.cnt == 8'd0) ? ST_ERR : ST_DONE;
                        r_res.ref_count <= (w_rd.cnt == 8'd0) ? w_rd.cnt
                                                              : w_rd.cnt - 8'd1;
                    end
                    r_out_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a result is only shown in the output state
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT) else $error("result outside output state");
    // a pending result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid) else $error("result dropped");
    // a fill is reported only with a miss allocation
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.needs_fill |-> o_out_data.status == ST_MISS)
        else $error("fill without miss");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the block cache tag engine: a directed table of requests covering
// hits, misses, full buckets and bad slots, a count saturation run, then
// random traffic over a small pool of blocks, all compared against a local
// model of the tag store under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import hlbc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    hashed_lru_block_cache_tags DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Table row: request, whether a typed result applies, and that result
    typedef struct {
        t_in  req;
        bit   typed;
        t_out res;
    } t_row;

    // Local copy of the tag store
    t_entry cache_mem [SLOT_COUNT];
    t_out   pending_results [$];
    int     fail_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    int     n_taken;
    t_row   dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input t_out got, input t_out want);
        fail_count++;
        $display("mismatch %s: got %p want %p at %0t", what, got, want, $time);
    endtask

    // Predict the result of one request and update the local store
    function automatic t_out cache_predict(input t_in r);
        t_out o;
        int   bkt;
        int   s;
        bit   found;
        int   pick;
        logic [31:0] least;
        o = '0;
        if (r.opcode == OP_GET) begin
            bkt = r.block_number % NUM_BUCKETS;
            o.bucket_index = bkt[3:0];
            for (int w = 0; w < NUM_WAYS; w++) begin
                s = bkt * NUM_WAYS + w;
                if (cache_mem[s].vld && cache_mem[s].dev == r.device_id
                        && cache_mem[s].blk == r.block_number) begin
                    cache_mem[s].tick = r.now_tick;
                    if (cache_mem[s].cnt == 8'hff) o.status = ST_ERR;
                    else begin
                        o.status = ST_DONE;
                        cache_mem[s].cnt++;
                    end
                    o.way_index = w[2:0];
                    o.ref_count = cache_mem[s].cnt;
                    return o;
                end
            end
            found = 0;
            pick  = 0;
            least = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                s = bkt * NUM_WAYS + w;
                if (cache_mem[s].cnt == 0 && (!found || cache_mem[s].tick < least)) begin
                    found = 1;
                    least = cache_mem[s].tick;
                    pick  = w;
                end
            end
            if (!found) begin
                o.status = ST_FULL;
                return o;
            end
            s = bkt * NUM_WAYS + pick;
            cache_mem[s] = '{dev: r.device_id, blk: r.block_number, cnt: 8'd1,
                             tick: r.now_tick, vld: 1'b1};
            o.status     = ST_MISS;
            o.way_index  = pick[2:0];
            o.needs_fill = 1'b1;
            o.ref_count  = 8'd1;
            return o;
        end
        o.bucket_index = r.slot_bucket;
        o.way_index    = r.slot_way;
        if (r.slot_bucket >= NUM_BUCKETS || r.slot_way >= NUM_WAYS) begin
            o.status = ST_ERR;
            return o;
        end
        s = r.slot_bucket * NUM_WAYS + r.slot_way;
        o.status = ST_DONE;
        if (r.opcode == OP_PIN) begin
            if (cache_mem[s].cnt == 8'hff) o.status = ST_ERR;
            else cache_mem[s].cnt++;
        end else begin
            if (cache_mem[s].cnt == 0) o.status = ST_ERR;
            else cache_mem[s].cnt--;
        end
        o.ref_count = cache_mem[s].cnt;
        return o;
    endfunction

    // Send one beat, then hold until accepted
    task automatic send_beat(input t_in r, input bit typed, input t_out want);
        t_out p;
        logic [95:0] rnd;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
            @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = r;
        do @(posedge i_clk); while (o_in_stall);
        p = cache_predict(r);
        if (typed && p != want) report_mismatch("table", p, want);
        pending_results.push_back(p);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        rnd        = {$urandom, $urandom, $urandom};
        i_in_data  = rnd[$bits(t_in)-1:0];
    endtask

    function automatic t_in make_req(input logic [1:0] op, input logic [15:0] dev,
                                     input logic [31:0] blk, input logic [31:0] tk,
                                     input logic [3:0] sb, input logic [2:0] sw);
        t_in r;
        r = '{opcode: op, device_id: dev, block_number: blk, now_tick: tk,
              slot_bucket: sb, slot_way: sw};
        return r;
    endfunction

    function automatic t_out make_res(input logic [1:0] st, input logic [3:0] b,
                                      input logic [2:0] w, input logic f,
                                      input logic [7:0] c);
        t_out o;
        o = '{status: st, bucket_index: b, way_index: w, needs_fill: f, ref_count: c};
        return o;
    endfunction

    // Random request over a small pool so hits and full buckets happen
    function automatic t_in rand_req();
        t_in r;
        int  k;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        r = rnd[$bits(t_in)-1:0];
        k = $urandom_range(99, 0);
        if (k < 55) begin
            r.opcode = OP_GET;
            if ($urandom_range(9, 0) != 0) begin
                r.device_id    = 16'($urandom_range(2, 0));
                r.block_number = NUM_BUCKETS * $urandom_range(3, 0) + $urandom_range(2, 0);
                if ($urandom_range(4, 0) == 0) r.block_number = r.block_number + 32'hfffffff0;
            end
        end else begin
            r.opcode = 2'($urandom_range(3, 1));
            if ($urandom_range(19, 0) != 0) begin
                r.slot_bucket = 4'($urandom_range(2, 0));
                r.slot_way    = 3'($urandom_range(NUM_WAYS - 1, 0));
            end
        end
        return r;
    endfunction

    // Result checker and stall driver
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_taken++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected", o_out_data, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status != want.status)
                    report_mismatch("status", o_out_data, want);
                if (o_out_data.bucket_index != want.bucket_index)
                    report_mismatch("bucket", o_out_data, want);
                if (o_out_data.way_index != want.way_index)
                    report_mismatch("way", o_out_data, want);
                if (o_out_data.needs_fill != want.needs_fill)
                    report_mismatch("fill", o_out_data, want);
                if (o_out_data.ref_count != want.ref_count)
                    report_mismatch("count", o_out_data, want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // Long receiver hold-off while requests keep coming
    initial begin
        hold_off = 1'b0;
        wait (n_taken > 300);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        t_in r;
        fail_count     = 0;
        n_taken        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        foreach (cache_mem[i]) cache_mem[i] = '0;

        // Directed table; block 13 and 0 share bucket 0
        dir_rows = '{
            '{make_req(OP_GET, 16'h0, 32'h0, 32'h0, 4'h0, 3'h0), 1,
              make_res(ST_MISS, 4'd0, 3'd0, 1'b1, 8'd1)},
            '{make_req(OP_GET, 16'h0, 32'h0, 32'h5, 4'h0, 3'h0), 1,
              make_res(ST_DONE, 4'd0, 3'd0, 1'b0, 8'd2)},
            '{make_req(OP_GET, 16'hffff, 32'hffffffff, 32'hffffffff, 4'hf, 3'h7), 1,
              make_res(ST_MISS, 4'd8, 3'd0, 1'b1, 8'd1)},
            '{make_req(OP_GET, 16'h1, 32'd13, 32'h1, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_GET, 16'h2, 32'd26, 32'h2, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_GET, 16'h3, 32'd39, 32'h3, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_GET, 16'h4, 32'd52, 32'h4, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_GET, 16'h5, 32'd65, 32'h6, 4'h0, 3'h0), 1,
              make_res(ST_FULL, 4'd0, 3'd0, 1'b0, 8'd0)},
            '{make_req(OP_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0, 3'd4), 0, '0},
            '{make_req(OP_UNPIN, 16'h0, 32'h0, 32'h0, 4'd0, 3'd4), 1,
              make_res(ST_ERR, 4'd0, 3'd4, 1'b0, 8'd0)},
            '{make_req(OP_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0, 3'd3), 0, '0},
            '{make_req(OP_GET, 16'h5, 32'd65, 32'hffffffff, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0, 3'd4), 0, '0},
            '{make_req(OP_GET, 16'h6, 32'd78, 32'h7, 4'h0, 3'h0), 0, '0},
            '{make_req(OP_PIN, 16'h0, 32'h0, 32'h0, 4'd13, 3'd0), 1,
              make_res(ST_ERR, 4'd13, 3'd0, 1'b0, 8'd0)},
            '{make_req(OP_RELEASE, 16'h0, 32'h0, 32'h0, 4'd15, 3'd7), 1,
              make_res(ST_ERR, 4'd15, 3'd7, 1'b0, 8'd0)},
            '{make_req(OP_UNPIN, 16'h0, 32'h0, 32'h0, 4'd2, 3'd5), 1,
              make_res(ST_ERR, 4'd2, 3'd5, 1'b0, 8'd0)},
            '{make_req(OP_PIN, 16'h0, 32'h0, 32'h0, 4'd12, 3'd4), 1,
              make_res(ST_DONE, 4'd12, 3'd4, 1'b0, 8'd1)},
            '{make_req(OP_UNPIN, 16'h0, 32'h0, 32'h0, 4'd12, 3'd4), 1,
              make_res(ST_DONE, 4'd12, 3'd4, 1'b0, 8'd0)}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        // Saturate one slot by pins, then hit it at full count
        for (int i = 0; i < 256; i++) begin
            r = make_req(OP_PIN, 16'h0, 32'h0, 32'h0, 4'd0, 3'd0);
            send_beat(r, 0, '0);
        end
        send_beat(make_req(OP_GET, 16'h0, 32'h0, 32'h9, 4'h0, 3'h0), 1,
                  make_res(ST_ERR, 4'd0, 3'd0, 1'b0, 8'd255));
        for (int i = 0; i < 256; i++)
            send_beat(make_req(OP_RELEASE, 16'h0, 32'h0, 32'h0, 4'd0, 3'd0), 0, '0);

        // Random traffic over idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 240; i++) send_beat(rand_req(), 0, '0);
        end

        wait (pending_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
